@@ rtl/jac_pkg.sv @@
`default_nettype none
package jac_pkg;

    localparam int ADC_BITS_DEF   = 12;
    localparam int OVERSAMPLE_DEF = 8;
    localparam int CAL_DEF        = 64;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int SW = 12;  // sample and centre width
    localparam int AW = 18;  // accumulator width
    localparam int CW = 7;   // run counter width
    localparam int DZW = 14; // deadzone register width

    localparam logic [SW-1:0] CENTRE_RESET = 12'd2048;

    localparam logic [2:0] REG_DEADZONE    = 3'd0;
    localparam logic [2:0] REG_INVERT_X    = 3'd1;
    localparam logic [2:0] REG_INVERT_Y    = 3'd2;
    localparam logic [2:0] REG_FULL_SCALE  = 3'd3;
    localparam logic [2:0] REG_CENTRE_LOW  = 3'd4;
    localparam logic [2:0] REG_CENTRE_HIGH = 3'd5;

    localparam logic [DZW-1:0] DEADZONE_RESET   = 14'd983;
    localparam logic [SW-1:0]  FULL_SCALE_RESET = 12'd4095;
    localparam logic [SW-1:0]  LOW_LIMIT_RESET  = 12'd1700;
    localparam logic [SW-1:0]  HIGH_LIMIT_RESET = 12'd2300;

    typedef struct packed {
        logic          func;
        logic [SW-1:0] sample_x;
        logic [SW-1:0] sample_y;
    } t_in_word;

    typedef struct packed {
        logic                result_kind;
        logic [SW-1:0]       avg_x;
        logic [SW-1:0]       avg_y;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic                at_rest;
        logic [SW-1:0]       centre_x_now;
        logic [SW-1:0]       centre_y_now;
        logic                centre_bad;
    } t_out_word;

    typedef struct packed {
        logic [DZW-1:0] deadzone;
        logic [SW-1:0]  full_scale;
        logic           invert;
    } t_lane_cfg;

endpackage
`default_nettype wire

@@ rtl/joystick_axis_conditioner.sv @@
// Joystick axis conditioner.
// Input channel: i_in_valid / o_in_stall carry one word with a kind and an
// X and Y ADC sample. Measure words are summed over OVERSAMPLE_COUNT words,
// calibration words over CAL_COUNT words; a change of kind restarts the run.
// Output channel: o_out_valid / i_out_stall carry one result word per
// completed run, held in an output register until taken.
// A word that does not complete a run is taken while the lanes are idle.
// A word that completes a run starts both axis lanes; each lane averages
// with a reciprocal multiply, then runs up to two bit-serial divisions
// (span normalization, deadzone rescale) on WN-bit dividends, WN = max(18,
// 2*FRAC_BITS+1, 12+FRAC_BITS). The deadzone can cut the rescale, and a
// calibration run uses neither division. While lanes work, and while a
// finished result waits for a full output register, o_in_stall is high and
// no word is taken; the next word can be taken at the first edge after the
// result appears.
// Reset (synchronous, active low) returns centers to 2048, clears sums,
// run count and valids, and loads the default configuration registers.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
`default_nettype none
module joystick_axis_conditioner #(
    parameter int OVERSAMPLE_COUNT = jac_pkg::OVERSAMPLE_DEF,
    parameter int CAL_COUNT        = jac_pkg::CAL_DEF,
    parameter int FRAC_BITS        = jac_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire jac_pkg::t_in_word       i_in_word,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output jac_pkg::t_out_word           o_out_word,
    input  wire logic                    i_cfg_we,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [jac_pkg::DZW-1:0] i_cfg_data
);
    import jac_pkg::*;

    localparam logic [CW-1:0] OVS_T = CW'(OVERSAMPLE_COUNT);
    localparam logic [CW-1:0] CAL_T = CW'(CAL_COUNT);

    // Configuration registers.
    logic [DZW-1:0] r_deadzone;
    logic           r_inv_x, r_inv_y;
    logic [SW-1:0]  r_full_scale, r_low_lim, r_high_lim;

    // Run state.
    logic [SW-1:0] r_centre_x, r_centre_y;
    logic [AW-1:0] r_sum_x, r_sum_y;
    logic [CW-1:0] r_count;
    logic          r_kind;

    // Job handed to the lanes.
    logic          r_busy;
    logic          r_start;
    logic          r_job_kind;
    logic [AW-1:0] r_job_x, r_job_y;
    logic          r_done_x, r_done_y;

    logic          r_out_valid;
    t_out_word     r_out_word;

    logic          in_acc;
    logic          same;
    logic [AW-1:0] n_sum_x, n_sum_y;
    logic [CW-1:0] n_count, target;
    logic          complete;
    logic          out_free;
    logic          merge;

    logic          done_x, done_y, zero_x, zero_y;
    logic [SW-1:0] avg_x, avg_y;
    logic signed [15:0] pos_x, pos_y;
    t_lane_cfg     cfg_x, cfg_y;
    t_out_word     res;

    assign o_in_stall = r_busy;
    assign in_acc     = i_in_valid && !r_busy;

    always_comb begin
        same     = (i_in_word.func == r_kind);
        n_sum_x  = (same ? r_sum_x : '0) + AW'(i_in_word.sample_x);
        n_sum_y  = (same ? r_sum_y : '0) + AW'(i_in_word.sample_y);
        n_count  = (same ? r_count : '0) + 1'b1;
        target   = i_in_word.func ? CAL_T : OVS_T;
        complete = (n_count >= target);
    end

    assign cfg_x = '{deadzone: r_deadzone, full_scale: r_full_scale, invert: r_inv_x};
    assign cfg_y = '{deadzone: r_deadzone, full_scale: r_full_scale, invert: r_inv_y};

    jac_lane #(
        .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT),
        .CAL_COUNT        (CAL_COUNT),
        .FRAC_BITS        (FRAC_BITS)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_kind   (r_job_kind),
        .i_sum    (r_job_x),
        .i_centre (r_centre_x),
        .i_cfg    (cfg_x),
        .o_done   (done_x),
        .o_avg    (avg_x),
        .o_pos    (pos_x),
        .o_zero   (zero_x)
    );

    jac_lane #(
        .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT),
        .CAL_COUNT        (CAL_COUNT),
        .FRAC_BITS        (FRAC_BITS)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_kind   (r_job_kind),
        .i_sum    (r_job_y),
        .i_centre (r_centre_y),
        .i_cfg    (cfg_y),
        .o_done   (done_y),
        .o_avg    (avg_y),
        .o_pos    (pos_y),
        .o_zero   (zero_y)
    );

    // The merge stage waits for both lanes and a free output register.
    assign out_free = !r_out_valid || !i_out_stall;
    assign merge    = r_busy && r_done_x && r_done_y && out_free;

    always_comb begin
        res.result_kind = r_job_kind;
        res.avg_x       = avg_x;
        res.avg_y       = avg_y;
        if (r_job_kind) begin
            res.pos_x        = '0;
            res.pos_y        = '0;
            res.at_rest      = 1'b0;
            res.centre_x_now = avg_x;
            res.centre_y_now = avg_y;
            res.centre_bad   = (avg_x < r_low_lim) || (avg_x > r_high_lim) ||
                               (avg_y < r_low_lim) || (avg_y > r_high_lim);
        end else begin
            res.pos_x        = pos_x;
            res.pos_y        = pos_y;
            res.at_rest      = zero_x && zero_y;
            res.centre_x_now = r_centre_x;
            res.centre_y_now = r_centre_y;
            res.centre_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone   <= DEADZONE_RESET;
            r_inv_x      <= 1'b0;
            r_inv_y      <= 1'b0;
            r_full_scale <= FULL_SCALE_RESET;
            r_low_lim    <= LOW_LIMIT_RESET;
            r_high_lim   <= HIGH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEADZONE:    r_deadzone   <= i_cfg_data;
                REG_INVERT_X:    r_inv_x      <= i_cfg_data[0];
                REG_INVERT_Y:    r_inv_y      <= i_cfg_data[0];
                REG_FULL_SCALE:  r_full_scale <= i_cfg_data[SW-1:0];
                REG_CENTRE_LOW:  r_low_lim    <= i_cfg_data[SW-1:0];
                REG_CENTRE_HIGH: r_high_lim   <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x  <= CENTRE_RESET;
            r_centre_y  <= CENTRE_RESET;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_count     <= '0;
            r_kind      <= 1'b0;
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_done_x    <= 1'b0;
            r_done_y    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= in_acc && complete;
            if (in_acc) begin
                r_kind <= i_in_word.func;
                if (complete) begin
                    r_sum_x  <= '0;
                    r_sum_y  <= '0;
                    r_count  <= '0;
                    r_busy   <= 1'b1;
                    r_done_x <= 1'b0;
                    r_done_y <= 1'b0;
                end else begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_count <= n_count;
                end
            end
            if (done_x) r_done_x <= 1'b1;
            if (done_y) r_done_y <= 1'b1;
            if (merge) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                if (r_job_kind) begin
                    r_centre_x <= avg_x;
                    r_centre_y <= avg_y;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && complete) begin
            r_job_kind <= i_in_word.func;
            r_job_x    <= n_sum_x;
            r_job_y    <= n_sum_y;
        end
        if (merge) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
endmodule
`default_nettype wire

@@ rtl/jac_div.sv @@
`default_nettype none
module jac_div #(
    parameter int WN = 29,
    parameter int WD = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [WN-1:0] i_num,
    input  wire logic [WD-1:0] i_den,
    output logic               o_done,
    output logic [WN-1:0]      o_quo
);
    localparam int CNTW = $clog2(WN + 1);

    logic [CNTW-1:0] r_cnt;
    logic [WN-1:0]   r_num;
    logic [WD-1:0]   r_rem;
    logic [WD-1:0]   r_den;
    logic            r_done;
    logic [WD:0]     trial;
    logic [WD:0]     diff;
    logic            fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb begin
        trial = {r_rem, r_num[WN-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_cnt <= CNTW'(WN);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[WN-2:0], fits};
            r_rem <= fits ? diff[WD-1:0] : trial[WD-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule
`default_nettype wire

@@ rtl/jac_lane.sv @@
`default_nettype none
module jac_lane #(
    parameter int OVERSAMPLE_COUNT = jac_pkg::OVERSAMPLE_DEF,
    parameter int CAL_COUNT        = jac_pkg::CAL_DEF,
    parameter int FRAC_BITS        = jac_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_kind,
    input  wire logic [jac_pkg::AW-1:0] i_sum,
    input  wire logic [jac_pkg::SW-1:0] i_centre,
    input  wire jac_pkg::t_lane_cfg    i_cfg,
    output logic                       o_done,
    output logic [jac_pkg::SW-1:0]     o_avg,
    output logic signed [15:0]         o_pos,
    output logic                       o_zero
);
    import jac_pkg::*;

    localparam int WA = (AW > 2 * FRAC_BITS + 1) ? AW : 2 * FRAC_BITS + 1;
    localparam int WN = (WA > SW + FRAC_BITS) ? WA : SW + FRAC_BITS;
    localparam int WD = (SW > FRAC_BITS + 1) ? SW : FRAC_BITS + 1;

    // The run average divides by a fixed run length, so it is a multiply by
    // a rounded-up reciprocal; RK fraction bits keep it exact for every sum.
    localparam int RK = AW + CW;
    localparam int RW = RK + 1;
    localparam int PW = AW + RW;
    localparam logic [RW-1:0] OVS_RECIP =
        RW'(((longint'(1) << RK) + longint'(OVERSAMPLE_COUNT) - 1) /
            longint'(OVERSAMPLE_COUNT));
    localparam logic [RW-1:0] CAL_RECIP =
        RW'(((longint'(1) << RK) + longint'(CAL_COUNT) - 1) / longint'(CAL_COUNT));

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_AVG  = 3'd1;
    localparam logic [2:0] L_NORM = 3'd2;
    localparam logic [2:0] L_DZ   = 3'd3;

    localparam logic [WN-1:0] ONE_Q = WN'(1) << FRAC_BITS;

    logic [2:0]    r_state, n_state;
    logic          r_go, n_go;
    logic [WN-1:0] r_dnum, n_dnum;
    logic [WD-1:0] r_dden, n_dden;
    logic          r_neg, n_neg;
    logic [SW-1:0] r_avg, n_avg;
    logic signed [15:0] r_pos, n_pos;
    logic          r_zero, n_zero;
    logic          r_done, n_done;
    logic [PW-1:0] r_prod, n_prod;

    logic          div_done;
    logic [WN-1:0] quo;
    logic [SW-1:0] avg_now;
    logic [SW-1:0] diff;
    logic [SW-1:0] span;
    logic [WN-1:0] mag;
    logic [WN-1:0] dz_w;
    logic [WN-1:0] fin_mag;
    logic          fin;
    logic          sign;

    jac_div #(.WN(WN), .WD(WD)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        n_dnum  = r_dnum;
        n_dden  = r_dden;
        n_neg   = r_neg;
        n_avg   = r_avg;
        n_pos   = r_pos;
        n_zero  = r_zero;
        n_done  = 1'b0;
        fin     = 1'b0;
        fin_mag = '0;
        n_prod  = PW'(i_sum) * PW'(i_kind ? CAL_RECIP : OVS_RECIP);
        avg_now = r_prod[RK +: SW];
        dz_w    = WN'(i_cfg.deadzone);
        mag     = (quo > ONE_Q) ? ONE_Q : quo;
        if (avg_now >= i_centre) begin
            diff = avg_now - i_centre;
            span = (i_cfg.full_scale > i_centre) ? i_cfg.full_scale - i_centre : SW'(1);
        end else begin
            diff = i_centre - avg_now;
            span = (i_centre != '0) ? i_centre : SW'(1);
        end
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = L_AVG;
                end
            end
            L_AVG: begin
                n_avg = avg_now;
                if (i_kind) begin
                    n_pos   = '0;
                    n_zero  = 1'b1;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else begin
                    n_neg   = (avg_now < i_centre);
                    n_go    = 1'b1;
                    n_dnum  = WN'(diff) << FRAC_BITS;
                    n_dden  = WD'(span);
                    n_state = L_NORM;
                end
            end
            L_NORM: begin
                if (div_done) begin
                    if (mag < dz_w) begin
                        fin     = 1'b1;
                        fin_mag = '0;
                    end else if (dz_w >= ONE_Q) begin
                        fin     = 1'b1;
                        fin_mag = ONE_Q;
                    end else begin
                        n_go    = 1'b1;
                        n_dnum  = (mag - dz_w) << FRAC_BITS;
                        n_dden  = WD'(ONE_Q - dz_w);
                        n_state = L_DZ;
                    end
                end
            end
            L_DZ: begin
                if (div_done) begin
                    fin     = 1'b1;
                    fin_mag = quo;
                end
            end
            default: n_state = L_IDLE;
        endcase
        // Sign and 16-bit saturation of the finished magnitude.
        sign = r_neg ^ i_cfg.invert;
        if (fin) begin
            n_done  = 1'b1;
            n_state = L_IDLE;
            n_zero  = (fin_mag == '0);
            if (!sign) begin
                n_pos = (fin_mag > WN'(32767)) ? 16'sh7FFF : signed'(fin_mag[15:0]);
            end else begin
                n_pos = (fin_mag > WN'(32768)) ? 16'sh8000 : signed'(16'(-fin_mag[15:0]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dnum <= n_dnum;
        r_dden <= n_dden;
        r_neg  <= n_neg;
        r_avg  <= n_avg;
        r_pos  <= n_pos;
        r_zero <= n_zero;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_avg  = r_avg;
    assign o_pos  = r_pos;
    assign o_zero = r_zero;
endmodule
`default_nettype wire

@@ tb/sv/joystick_axis_conditioner_checker.sv @@
`default_nettype none
module joystick_axis_conditioner_checker (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire jac_pkg::t_in_word       i_in_word,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire jac_pkg::t_out_word      i_out_word,
    input  wire logic                    i_cfg_we,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [jac_pkg::DZW-1:0] i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);
    import jac_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint ONE_Q = longint'(1) << FRAC;

    logic [DZW-1:0] dz_reg;
    logic           inv_x_reg, inv_y_reg;
    logic [SW-1:0]  full_scale_reg, low_lim_reg, high_lim_reg;
    logic [SW-1:0]  cen_x, cen_y;
    logic [AW-1:0]  acc_x, acc_y;
    logic [CW-1:0]  run_len;
    logic           run_is_cal;

    t_out_word expected_words[$];

    assign o_pending = expected_words.size();

    // Normalize one averaged reading against its center, then apply the
    // deadzone with rescaling. Quotients truncate toward zero.
    function automatic longint axis_position(input logic [SW-1:0] raw,
                                             input logic [SW-1:0] cen);
        longint mag, dz, span;
        logic neg;
        dz = longint'(dz_reg);
        if (raw >= cen) begin
            span = (full_scale_reg > cen) ? longint'(full_scale_reg - cen) : 1;
            mag = (longint'(raw - cen) << FRAC) / span;
            neg = 1'b0;
        end else begin
            span = (cen > 0) ? longint'(cen) : 1;
            mag = (longint'(cen - raw) << FRAC) / span;
            neg = 1'b1;
        end
        if (mag > ONE_Q) mag = ONE_Q;
        if (mag < dz) return 0;
        if (dz >= ONE_Q) mag = ONE_Q;
        else mag = ((mag - dz) << FRAC) / (ONE_Q - dz);
        return neg ? -mag : mag;
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic accept_sample(input t_in_word w);
        t_out_word r;
        int target;
        longint px, py;
        if (w.func != run_is_cal) begin
            run_is_cal = w.func;
            acc_x = '0;
            acc_y = '0;
            run_len = '0;
        end
        acc_x = acc_x + w.sample_x;
        acc_y = acc_y + w.sample_y;
        run_len = run_len + 1'b1;
        target = w.func ? CAL_DEF : OVERSAMPLE_DEF;
        if (run_len < target) return;
        r = '0;
        r.result_kind = w.func;
        r.avg_x = SW'(acc_x / target);
        r.avg_y = SW'(acc_y / target);
        acc_x = '0;
        acc_y = '0;
        run_len = '0;
        if (w.func) begin
            cen_x = r.avg_x;
            cen_y = r.avg_y;
            r.centre_bad = (r.avg_x < low_lim_reg || r.avg_x > high_lim_reg ||
                            r.avg_y < low_lim_reg || r.avg_y > high_lim_reg);
        end else begin
            px = axis_position(r.avg_x, cen_x);
            py = axis_position(r.avg_y, cen_y);
            if (inv_x_reg) px = -px;
            if (inv_y_reg) py = -py;
            r.pos_x = sat16(px);
            r.pos_y = sat16(py);
            r.at_rest = (px == 0 && py == 0);
        end
        r.centre_x_now = cen_x;
        r.centre_y_now = cen_y;
        expected_words.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            dz_reg <= DEADZONE_RESET;
            inv_x_reg <= 1'b0;
            inv_y_reg <= 1'b0;
            full_scale_reg <= FULL_SCALE_RESET;
            low_lim_reg <= LOW_LIMIT_RESET;
            high_lim_reg <= HIGH_LIMIT_RESET;
            cen_x = CENTRE_RESET;
            cen_y = CENTRE_RESET;
            acc_x = '0;
            acc_y = '0;
            run_len = '0;
            run_is_cal = 1'b0;
            o_errors <= 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEADZONE:    dz_reg <= i_cfg_data;
                    REG_INVERT_X:    inv_x_reg <= i_cfg_data[0];
                    REG_INVERT_Y:    inv_y_reg <= i_cfg_data[0];
                    REG_FULL_SCALE:  full_scale_reg <= i_cfg_data[SW-1:0];
                    REG_CENTRE_LOW:  low_lim_reg <= i_cfg_data[SW-1:0];
                    REG_CENTRE_HIGH: high_lim_reg <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) accept_sample(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_out_word);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (e !== i_out_word) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, e, i_out_word);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/sv/joystick_axis_conditioner_tb.sv @@
`default_nettype none
module joystick_axis_conditioner_tb;
    import jac_pkg::*;

    // Longest quiet stretch: the lane work plus the longest random stall on
    // each side, taken many times over.
    localparam int QUIET_LIMIT = 5000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    t_in_word       in_word;
    logic           out_valid;
    logic           out_stall;
    t_out_word      out_word;
    logic           cfg_we;
    logic [2:0]     cfg_index;
    logic [DZW-1:0] cfg_data;
    int             errors;
    int             pending;
    int             quiet_cycles;

    joystick_axis_conditioner dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    joystick_axis_conditioner_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls for a random number of cycles before each word,
    // sometimes not at all so that back-to-back results are exercised.
    initial begin
        int gap;
        out_stall = 1'b1;
        @(posedge clk iff rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            repeat (gap) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk iff out_valid);
        end
    end

    // Watchdog: a run of cycles with nothing accepted on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("joystick_axis_conditioner_tb: FAIL");
            $finish;
        end
    end

    // Sends one word after a random gap and holds it until it is taken.
    // Valid stays high after the taking edge so a following word can go
    // back to back; wait_idle drops it.
    task automatic send_word(input logic kind, input logic [11:0] sx,
                             input logic [11:0] sy, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word <= '{func: kind, sample_x: sx, sample_y: sy};
        @(posedge clk iff !in_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DZW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // A full measure run of readings spread above a chosen point.
    task automatic measure_run(input logic [11:0] cx, input logic [11:0] cy,
                               input int spread, input bit tight);
        for (int k = 0; k < OVERSAMPLE_DEF; k++)
            send_word(1'b0,
                      12'(int'(cx) + $urandom_range(0, spread)),
                      12'(int'(cy) + $urandom_range(0, spread)), tight);
    endtask

    task automatic cal_run(input logic [11:0] cx, input logic [11:0] cy,
                           input int spread);
        for (int k = 0; k < CAL_DEF; k++)
            send_word(1'b1, 12'(int'(cx) + $urandom_range(0, spread)),
                      12'(int'(cy) + $urandom_range(0, spread)),
                      $urandom_range(0, 3) != 0);
    endtask

    task automatic random_phase(input int runs);
        for (int r = 0; r < runs; r++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // A broken run: one to five words, each of a random kind.
                    repeat ($urandom_range(1, 5))
                        send_word(1'($urandom), 12'($urandom), 12'($urandom), 1'b0);
                end
                1: measure_run(12'($urandom), 12'($urandom), 0, 1'b1);
                2: measure_run({12{1'b1}}, 12'd0, 0, 1'b0);
                default:
                    measure_run(12'($urandom_range(0, 4000)),
                                12'($urandom_range(0, 4000)), 95,
                                $urandom_range(0, 1));
            endcase
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DEADZONE;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: center, both extremes, a kind change mid-run.
        measure_run(12'd2048, 12'd2048, 0, 1'b1);
        measure_run(12'd4095, 12'd0, 0, 1'b0);
        measure_run(12'd0, 12'd4095, 0, 1'b1);
        send_word(1'b1, 12'd100, 12'd200, 1'b0);
        measure_run(12'd2100, 12'd1990, 0, 1'b0);
        wait_idle();

        // Default settings, then a calibration run off center.
        random_phase(7);
        cal_run(12'd1500, 12'd2500, 3);
        random_phase(5);
        wait_idle();

        // Inverted axes, zero deadzone, short full scale so readings
        // above it clamp.
        write_reg(REG_DEADZONE, 14'd0);
        write_reg(REG_INVERT_X, 14'd1);
        write_reg(REG_INVERT_Y, 14'd1);
        write_reg(REG_FULL_SCALE, 14'd3000);
        write_reg(REG_CENTRE_LOW, 14'd0);
        write_reg(REG_CENTRE_HIGH, 14'd4095);
        cal_run(12'd2000, 12'd2990, 4);
        random_phase(8);
        wait_idle();

        // Centers at zero and at full scale give zero spans; crossed limits
        // flag every center; the widest deadzone pins positions.
        write_reg(REG_DEADZONE, 14'h3FFF);
        write_reg(REG_INVERT_X, 14'd0);
        write_reg(REG_FULL_SCALE, 14'd0);
        write_reg(REG_CENTRE_LOW, 14'd4095);
        write_reg(REG_CENTRE_HIGH, 14'd0);
        cal_run(12'd0, 12'd0, 0);
        random_phase(5);
        cal_run(12'd4095, 12'd4095, 0);
        random_phase(4);
        wait_idle();

        // Deadzone of one below full deflection, then a mid value.
        write_reg(REG_DEADZONE, 14'd16383);
        write_reg(REG_FULL_SCALE, 14'd4095);
        write_reg(REG_INVERT_Y, 14'd0);
        cal_run(12'd2048, 12'd2048, 1);
        random_phase(4);
        wait_idle();
        write_reg(REG_DEADZONE, 14'd4000);
        write_reg(REG_CENTRE_LOW, 14'd1700);
        write_reg(REG_CENTRE_HIGH, 14'd2300);
        random_phase(7);

        wait_idle();
        if (errors == 0)
            $display("joystick_axis_conditioner_tb: PASS");
        else
            $display("joystick_axis_conditioner_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
